// ----- src/huffman_encode_bit_packer_assert.svh -----
// Assertion macros for the Huffman encoder with bit packer.
`ifndef HUFFMAN_ENCODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_ENCODE_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HEP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HEP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hep_pkg.sv -----
// Shared types and constants for the Huffman encoder with bit packer.
package hep_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int NUM_SYMBOLS_DEF  = 256;
  localparam int FIFO_DEPTH_DEF   = 4;

  localparam int BYTE_W = 8;
  localparam int SYM_W  = 8;
  localparam int WORD_W = 32;
  localparam int LEN_W  = 6;
  localparam int CFG_W  = 32;
  localparam int PEND_W = 7;
  localparam int ACC_W  = PEND_W + WORD_W;
  localparam int CNT_W  = 6;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_START  = 2'd1,
    CMD_ENCODE = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [SYM_W-1:0]  symbol;
    logic [WORD_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } out_item_t;

  // Work handed from front to back; word holds the header value for start.
  typedef struct packed {
    cmd_t              cmd;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
  } job_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] cnt;
  } bk_stat_t;

endpackage

// ----- src/hep_chan_if.sv -----
// Valid/ready channel interface carrying a payload of any type.
interface hep_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/hep_front.sv -----
// Front end: accepts commands, owns the code tables and queues work for the packer.
module hep_front #(
  parameter int NUM_SYMBOLS  = hep_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = hep_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  hep_pkg::in_item_t       in_item,
  input  logic                    cfg_valid,
  input  logic [hep_pkg::CFG_W-1:0] cfg_data,
  output logic                    job_valid,
  input  logic                    job_ready,
  output hep_pkg::job_t           job
);
  import hep_pkg::*;

  localparam int LEN_LIM = (MAX_CODE_LEN > WORD_W) ? WORD_W : MAX_CODE_LEN;
  localparam int LEN_SW  = $clog2(LEN_LIM + 1);
  localparam int AW      = $clog2(NUM_SYMBOLS);

  cmd_t              in_cmd;
  logic              accept;
  logic              sym_ok;
  logic              st_push;
  logic              st_adv;
  logic [AW-1:0]     addr;
  logic [LEN_W-1:0]  clamp_len;
  logic [WORD_W:0]   mask;

  logic [2:0]        tb_low_r;
  logic              st_valid_r;
  cmd_t              st_cmd_r;
  logic              st_keep_r;
  logic              st_lv_r;
  logic [2:0]        st_hdr_r;
  logic [LEN_SW-1:0] rd_len_r;
  logic [WORD_W-1:0] rd_word_r;
  logic [NUM_SYMBOLS-1:0] len_vld_r;

  logic [LEN_SW-1:0] len_mem  [NUM_SYMBOLS];
  logic [WORD_W-1:0] word_mem [NUM_SYMBOLS];

  always_comb begin
    in_cmd    = cmd_t'(in_item.command);
    sym_ok    = {1'b0, in_item.symbol} < (SYM_W + 1)'(NUM_SYMBOLS);
    addr      = in_item.symbol[AW-1:0];
    clamp_len = (in_item.code_length > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM)
                                                        : in_item.code_length;
    mask      = ({{WORD_W{1'b0}}, 1'b1} << clamp_len) - 1'b1;
    // encodes of absent, out-of-range or zero-length symbols are dropped here
    st_push   = st_valid_r && ((st_cmd_r != CMD_ENCODE) ||
                               (st_keep_r && st_lv_r && (rd_len_r != '0)));
    st_adv    = !st_push || job_ready;
    in_ready  = st_adv;
    accept    = in_valid && in_ready;
    job_valid = st_push;
    job.cmd   = st_cmd_r;
    job.len   = st_lv_r ? LEN_W'(rd_len_r) : '0;
    job.word  = (st_cmd_r == CMD_START) ? WORD_W'(st_hdr_r) : rd_word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_low_r   <= '0;
      st_valid_r <= 1'b0;
      len_vld_r  <= '0;
    end else begin
      if (cfg_valid) begin
        tb_low_r <= cfg_data[2:0];
      end
      if (st_adv) begin
        st_valid_r <= accept && (in_cmd != CMD_LOAD);
      end
      if (accept && (in_cmd == CMD_LOAD) && sym_ok) begin
        len_vld_r[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_cmd_r  <= in_cmd;
      st_keep_r <= sym_ok;
      st_lv_r   <= sym_ok && len_vld_r[addr];
      st_hdr_r  <= 3'(3'd0 - tb_low_r);
    end
  end

  // code tables, registered read
  always_ff @(posedge clk) begin
    if (accept && (in_cmd == CMD_LOAD) && sym_ok) begin
      len_mem[addr]  <= LEN_SW'(clamp_len);
      word_mem[addr] <= in_item.code_bits & mask[WORD_W-1:0];
    end
    if (accept) begin
      rd_len_r  <= len_mem[addr];
      rd_word_r <= word_mem[addr];
    end
  end

endmodule

// ----- src/hep_fifo.sv -----
// Short job queue between the front end and the packer.
module hep_fifo #(
  parameter int DEPTH = hep_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  hep_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output hep_pkg::job_t pop_data
);
  import hep_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic          push;
  logic          pop;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  job_t          head_r;
  job_t          mem [DEPTH];

  always_comb begin
    push_ready = count_r != CW'(DEPTH);
    pop_valid  = count_r != '0;
    pop_data   = head_r;
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    // head entry; the incoming job goes straight through when it lands at the head
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_data;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

endmodule

// ----- src/hep_back.sv -----
// Back end: bit packer that turns queued work into output bytes.
module hep_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  hep_pkg::job_t      job,
  output logic               out_valid,
  input  logic               out_ready,
  output hep_pkg::out_item_t out_item,
  output hep_pkg::bk_stat_t  stat
);
  import hep_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EMIT = 2'b10
  } bstate_t;

  function automatic logic [PEND_W-1:0] keep_low(logic [PEND_W-1:0] b, logic [2:0] c);
    logic [BYTE_W-1:0] m;
    m = (BYTE_W'(1) << c) - 1'b1;
    return b & m[PEND_W-1:0];
  endfunction

  bstate_t             state_r, state_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PEND_W-1:0]   pend_bits_r, pend_bits_nxt;
  logic [2:0]          pend_cnt_r, pend_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;

  logic                out_free;
  logic                emit;
  logic [BYTE_W-1:0]   emit_byte;
  logic                emit_last;
  logic [ACC_W-1:0]    acc_ld;
  logic [CNT_W-1:0]    cnt_ld;
  logic [CNT_W-1:0]    cnt_dec;
  logic [ACC_W-1:0]    emit_sh;
  logic [PEND_W+BYTE_W-1:0] flush_sh;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    acc_ld   = (ACC_W'(pend_bits_r) << job.len) | ACC_W'(job.word);
    cnt_ld   = CNT_W'(pend_cnt_r) + CNT_W'(job.len);
    cnt_dec  = cnt_r - CNT_W'(BYTE_W);
    emit_sh  = acc_r >> cnt_dec;
    // partial byte, zero padded on the right
    flush_sh = (PEND_W + BYTE_W)'(pend_bits_r) << (4'(BYTE_W) - 4'(pend_cnt_r));

    state_nxt     = state_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    job_ready     = 1'b0;
    emit          = 1'b0;
    emit_byte     = '0;
    emit_last     = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          unique case (job.cmd)
            CMD_START: begin
              if (out_free) begin
                job_ready     = 1'b1;
                emit          = 1'b1;
                emit_byte     = job.word[BYTE_W-1:0];
                emit_last     = 1'b1;
                pend_bits_nxt = '0;
                pend_cnt_nxt  = '0;
              end
            end
            CMD_FLUSH: begin
              if (pend_cnt_r == '0) begin
                job_ready = 1'b1;
              end else if (out_free) begin
                job_ready     = 1'b1;
                emit          = 1'b1;
                emit_byte     = flush_sh[BYTE_W-1:0];
                emit_last     = 1'b1;
                pend_bits_nxt = '0;
                pend_cnt_nxt  = '0;
              end
            end
            CMD_ENCODE: begin
              job_ready = 1'b1;
              if (cnt_ld >= CNT_W'(BYTE_W)) begin
                state_nxt = B_EMIT;
                acc_nxt   = acc_ld;
                cnt_nxt   = cnt_ld;
              end else begin
                pend_bits_nxt = keep_low(acc_ld[PEND_W-1:0], cnt_ld[2:0]);
                pend_cnt_nxt  = cnt_ld[2:0];
              end
            end
            default: begin
              job_ready = 1'b1;
            end
          endcase
        end
      end
      B_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = emit_sh[BYTE_W-1:0];
          cnt_nxt   = cnt_dec;
          if (cnt_dec < CNT_W'(BYTE_W)) begin
            emit_last     = 1'b1;
            pend_bits_nxt = keep_low(acc_r[PEND_W-1:0], cnt_dec[2:0]);
            pend_cnt_nxt  = cnt_dec[2:0];
            state_nxt     = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = emit_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    out_valid         = out_valid_r;
    out_item.out_byte = out_byte_r;
    out_item.last     = out_last_r;
    stat.busy         = state_r == B_EMIT;
    stat.cnt          = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ----- src/huffman_encode_bit_packer.sv -----
// Top level of the Huffman encoder with bit packer.
//
//  channel   dir  payload                                        transfer when
//  in_ch     in   command, symbol, code_bits, code_length        valid && ready
//  out_ch    out  out_byte, last                                 valid && ready
//  cfg_ch    in   total_bits (32 bits)                           valid && ready
//
// The packer takes an encode in its idle state, then emits each output byte it completes
// from its emit state; start and flush are done in the idle state; loads never reach it.
// The front end registers the code-table read, then the job passes through the queue.
// Reset clears the length-table valid bits at once; no clearing pass is needed.
// A stalled output holds the packer; the queue lets the front keep taking items.
`include "huffman_encode_bit_packer_assert.svh"

module huffman_encode_bit_packer #(
  parameter int MAX_CODE_LEN = hep_pkg::MAX_CODE_LEN_DEF,
  parameter int NUM_SYMBOLS  = hep_pkg::NUM_SYMBOLS_DEF,
  parameter int FIFO_DEPTH   = hep_pkg::FIFO_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  hep_chan_if.sink   in_ch,
  hep_chan_if.source out_ch,
  hep_chan_if.sink   cfg_ch
);
  import hep_pkg::*;

  in_item_t  in_item;
  out_item_t out_item;
  job_t      job;
  job_t      q_job;
  bk_stat_t  bk_stat;
  logic      in_ready;
  logic      job_valid;
  logic      job_ready;
  logic      q_valid;
  logic      q_ready;
  logic      out_valid;

  assign in_item      = in_ch.data;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  hep_front #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cfg_valid(cfg_ch.valid),
    .cfg_data (cfg_ch.data),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job      (job)
  );

  hep_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(job_valid),
    .push_ready(job_ready),
    .push_data (job),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_job)
  );

  hep_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(q_valid),
    .job_ready(q_ready),
    .job      (q_job),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .out_item (out_item),
    .stat     (bk_stat)
  );

  `HEP_ASSERT_NXT(a_job_hold, clk, rst_n, job_valid && !job_ready, job_valid && $stable(job), "stalled job changed")
  `HEP_ASSERT_IMP(a_mid_byte, clk, rst_n, out_valid && !out_item.last, bk_stat.busy, "non-final byte outside emit")
  `HEP_ASSERT_IMP(a_emit_cnt, clk, rst_n, bk_stat.busy, bk_stat.cnt >= CNT_W'(BYTE_W), "emit with under a byte")

endmodule
